// ----- rtl/wamf_pkg.sv -----
// ----------------------------------------------------------------------------
// wamf_pkg: shared constants of the window average / median filter
// Sample width default, ring depth and count width used by the interfaces
// and the filter datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package wamf_pkg;

  // default sample width, legal range 8..32
  localparam int unsigned SAMPLE_BITS = 16;

  // ring depth is fixed by the filter: three taps, divide by three
  localparam int unsigned RING_DEPTH  = 3;

  // width of the fill count and of samples_held (values 0..3)
  localparam int unsigned CNT_BITS    = 2;

  // width of a ring position (0..2)
  localparam int unsigned SLOT_BITS   = 2;

endpackage : wamf_pkg

`default_nettype wire

// ----- rtl/wamf_if.sv -----
// ----------------------------------------------------------------------------
// wamf_if: valid/ready channels of the window average / median filter
// wamf_sample_if carries one sample per item, wamf_result_if carries the
// average, median and number of held samples per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface wamf_sample_if #(
  parameter int unsigned SAMPLE_BITS = wamf_pkg::SAMPLE_BITS
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface : wamf_sample_if

interface wamf_result_if #(
  parameter int unsigned SAMPLE_BITS = wamf_pkg::SAMPLE_BITS
) ();
  logic                              valid;
  logic                              ready;
  logic signed [SAMPLE_BITS-1:0]     average;
  logic signed [SAMPLE_BITS-1:0]     median;
  logic [wamf_pkg::CNT_BITS-1:0]     samples_held;

  modport source (output valid, output average, output median, output samples_held,
                  input ready);
  modport sink   (input valid, input average, input median, input samples_held,
                  output ready);
endinterface : wamf_result_if

`default_nettype wire

// ----- rtl/window_average_median_filter.sv -----
// ----------------------------------------------------------------------------
// window_average_median_filter: three-tap moving average and median filter
// Keeps the last three samples in a ring with a running sum; each item
// yields the sum divided by three (truncated toward zero), the median of the
// three ring entries and the number of samples held.
// ----------------------------------------------------------------------------
// Pipeline: input register, ring/median stage, divide-by-three stage feeding
//   the output register; a stall in any stage holds the stages before it.
// Throughput: one item per cycle while result_o.ready does not stall the output;
//   the deepest path is the reciprocal multiply of the divide-by-three stage.
// Reset: rst_ni clears the ring, the running sum, fill count, write position
//   and all pipeline valid flags; the block takes items the cycle after.
`default_nettype none

module window_average_median_filter #(
  parameter int unsigned SAMPLE_BITS = wamf_pkg::SAMPLE_BITS
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  wamf_sample_if.sink   sample_i,
  wamf_result_if.source result_o
);

  localparam int unsigned SumW  = SAMPLE_BITS + 2;
  // magnitude of the sum is below 2^(SAMPLE_BITS+1)
  localparam int unsigned MagW  = SAMPLE_BITS + 1;
  localparam int unsigned RecK  = MagW + 1;
  localparam logic [RecK+1:0] RecipW =
    (((RecK+2)'(1) << RecK) + (RecK+2)'(2)) / (RecK+2)'(3);
  localparam logic [MagW-1:0] RecipC = RecipW[MagW-1:0];
  localparam int unsigned ProdW = 2 * MagW;

  localparam int unsigned CntW  = wamf_pkg::CNT_BITS;
  localparam int unsigned SlotW = wamf_pkg::SLOT_BITS;
  localparam int unsigned Depth = wamf_pkg::RING_DEPTH;
  localparam logic [CntW-1:0]  FullCnt = CntW'(Depth);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(Depth - 1);

  // input register
  logic                          in_v_q;
  logic signed [SAMPLE_BITS-1:0] in_sample_q;

  // filter state
  logic signed [SAMPLE_BITS-1:0] ring_q [Depth];
  logic signed [SAMPLE_BITS-1:0] ring_d [Depth];
  logic signed [SumW-1:0]        sum_q, sum_d;
  logic [CntW-1:0]               fill_q, fill_d;
  logic [SlotW-1:0]              slot_q, slot_d;

  // middle stage
  logic                          mid_v_q;
  logic signed [SumW-1:0]        mid_sum_q;
  logic signed [SAMPLE_BITS-1:0] mid_med_q;
  logic [CntW-1:0]               mid_cnt_q;

  // output register
  logic                          out_v_q;
  logic signed [SAMPLE_BITS-1:0] out_avg_q;
  logic signed [SAMPLE_BITS-1:0] out_med_q;
  logic [CntW-1:0]               out_cnt_q;

  logic                          out_free, mid_adv, mid_free, in_adv, in_take;
  logic                          full;
  logic signed [SAMPLE_BITS-1:0] old_sample, lo_ab, hi_ab, lo_hc, med_d;
  logic                          sum_neg;
  logic [SumW-1:0]               sum_abs;
  logic [MagW-1:0]               mag;
  logic [ProdW-1:0]              prod;
  logic [SAMPLE_BITS-1:0]        quot;
  logic signed [SAMPLE_BITS-1:0] avg_d;

  // stall chain
  assign out_free       = !out_v_q || result_o.ready;
  assign mid_adv        = mid_v_q && out_free;
  assign mid_free       = !mid_v_q || mid_adv;
  assign in_adv         = in_v_q && mid_free;
  assign sample_i.ready = !in_v_q || in_adv;
  assign in_take        = sample_i.valid && sample_i.ready;

  // ring update and median
  always_comb begin
    full       = (fill_q == FullCnt);
    old_sample = ring_q[slot_q];
    for (int i = 0; i < Depth; i++) begin
      ring_d[i] = (slot_q == SlotW'(i)) ? in_sample_q : ring_q[i];
    end
    sum_d  = sum_q - (full ? SumW'(old_sample) : SumW'(0)) + SumW'(in_sample_q);
    fill_d = full ? fill_q : fill_q + CntW'(1);
    slot_d = (slot_q == LastSlot) ? SlotW'(0) : slot_q + SlotW'(1);

    // med = max(min(a,b), min(max(a,b),c))
    lo_ab = (ring_d[0] < ring_d[1]) ? ring_d[0] : ring_d[1];
    hi_ab = (ring_d[0] < ring_d[1]) ? ring_d[1] : ring_d[0];
    lo_hc = (hi_ab < ring_d[2]) ? hi_ab : ring_d[2];
    med_d = (lo_ab < lo_hc) ? lo_hc : lo_ab;
  end

  // divide by three, truncated toward zero: reciprocal multiply on |sum|
  always_comb begin
    sum_neg = mid_sum_q[SumW-1];
    sum_abs = sum_neg ? SumW'(-mid_sum_q) : SumW'(mid_sum_q);
    mag     = sum_abs[MagW-1:0];
    prod    = ProdW'(mag) * ProdW'(RecipC);
    quot    = prod[ProdW-1:RecK];
    avg_d   = sum_neg ? SAMPLE_BITS'(-quot) : SAMPLE_BITS'(quot);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      mid_v_q <= 1'b0;
      out_v_q <= 1'b0;
      sum_q   <= '0;
      fill_q  <= '0;
      slot_q  <= '0;
      for (int i = 0; i < Depth; i++) begin
        ring_q[i] <= '0;
      end
    end else begin
      if (sample_i.ready) begin
        in_v_q <= sample_i.valid;
      end
      if (mid_free) begin
        mid_v_q <= in_v_q;
      end
      if (out_free) begin
        out_v_q <= mid_v_q;
      end
      if (in_adv) begin
        sum_q  <= sum_d;
        fill_q <= fill_d;
        slot_q <= slot_d;
        for (int i = 0; i < Depth; i++) begin
          ring_q[i] <= ring_d[i];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_sample_q <= sample_i.sample;
    end
    if (in_adv) begin
      mid_sum_q <= sum_d;
      mid_med_q <= med_d;
      mid_cnt_q <= fill_d;
    end
    if (mid_adv) begin
      out_avg_q <= avg_d;
      out_med_q <= mid_med_q;
      out_cnt_q <= mid_cnt_q;
    end
  end

  assign result_o.valid        = out_v_q;
  assign result_o.average      = out_avg_q;
  assign result_o.median       = out_med_q;
  assign result_o.samples_held = out_cnt_q;

  // while filling, writes go to slots in order
  a_fill_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != FullCnt) |-> (slot_q == SlotW'(fill_q)))
    else $error("write slot out of step with fill count");

  // running sum always matches the ring contents
  a_sum_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q == SumW'(ring_q[0]) + SumW'(ring_q[1]) + SumW'(ring_q[2]))
    else $error("running sum lost track of ring");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q != SlotW'(Depth))
    else $error("write slot past ring end");

  // a stalled middle stage keeps its item
  a_mid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mid_v_q && !mid_adv) |=> (mid_v_q && $stable(mid_sum_q) && $stable(mid_med_q)))
    else $error("middle stage item dropped under stall");

  a_result_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_cnt_q != '0))
    else $error("result with no samples held");

endmodule : window_average_median_filter

`default_nettype wire
